### sv/rwd_pkg.sv
// ----------------------------------------------------------------------------
// rwd_pkg: shared types and constants of the request worker dispatcher
// Holds the job record passed from the parser to the executor, the result
// record, state encodings, register indexes and character codes.
// ----------------------------------------------------------------------------
`default_nettype none

package rwd_pkg;

   localparam int KEY_W    = 32;
   localparam int STEP_W   = $clog2(KEY_W);
   localparam int COUNT_W  = 5;
   localparam int SLOT_W   = 4;

   localparam logic [7:0]       CHAR_SPACE = 8'd32;
   localparam logic [KEY_W-1:0] CHAR_ZERO  = 32'd48;

   // Configuration register indexes.
   localparam logic CSR_ROUTING_MODE = 1'b0;
   localparam logic CSR_WORKER_COUNT = 1'b1;

   // Routing modes.
   localparam logic MODE_ROUND_ROBIN = 1'b0;
   localparam logic MODE_KEY         = 1'b1;

   typedef enum logic [1:0] {
      PH_SEEK,
      PH_KEY,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_HOLD
   } bk_state_type;

   // One finished request as seen by the executor.
   typedef struct packed {
      logic             no_space;
      logic [KEY_W-1:0] key;
   } job_type;

   typedef struct packed {
      logic              no_key_found;
      logic              no_worker;
      logic [SLOT_W-1:0] worker_slot;
   } result_type;

endpackage

`default_nettype wire

### sv/rwd_front.sv
// ----------------------------------------------------------------------------
// rwd_front: request byte parser
// Tracks the position relative to the key field and folds the decimal key
// one accepted byte per cycle; the last byte emits a job and clears its state.
// ----------------------------------------------------------------------------
`default_nettype none

module rwd_front
   import rwd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       byte_accept,
   input  wire logic [7:0] byte_data,
   input  wire logic       byte_last,
   output logic            job_push,
   output job_type         job_data
);

   phase_type        phase_ff, phase_in, phase_next;
   logic [KEY_W-1:0] key_ff, key_in, key_next;

   always_comb begin
      phase_next = phase_ff;
      key_next   = key_ff;
      case (phase_ff)
         PH_SEEK: begin
            if (byte_data == CHAR_SPACE) phase_next = PH_KEY;
         end
         PH_KEY: begin
            if (byte_data == CHAR_SPACE) begin
               phase_next = PH_DONE;
            end else begin
               // key*10 as two shifted copies, then add the digit value.
               key_next = (key_ff << 3) + (key_ff << 1)
                          + ({{(KEY_W-8){1'b0}}, byte_data} - CHAR_ZERO);
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      key_in   = key_ff;
      if (byte_accept) begin
         if (byte_last) begin
            phase_in = PH_SEEK;
            key_in   = '0;
         end else begin
            phase_in = phase_next;
            key_in   = key_next;
         end
      end
   end

   assign job_push          = byte_accept && byte_last;
   assign job_data.key      = key_next;
   assign job_data.no_space = (phase_next == PH_SEEK);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SEEK;
         key_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         key_ff   <= key_in;
      end
   end

endmodule

`default_nettype wire

### sv/rwd_queue.sv
// ----------------------------------------------------------------------------
// rwd_queue: two-entry job queue
// Decouples the parser from the executor so each can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module rwd_queue
   import rwd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_data,
   input  wire logic    pop,
   output logic         full,
   output logic         not_empty,
   output job_type      head
);

   job_type     ent_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        do_push, do_pop;

   assign full      = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign head      = ent_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      cnt_in    = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (do_push) ent_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

`default_nettype wire

### sv/rwd_back.sv
// ----------------------------------------------------------------------------
// rwd_back: worker selection executor
// Takes jobs from the queue, advances the round-robin offset, flags a missing
// worker or key, or reduces the key modulo the worker count one quotient bit
// per cycle, and holds the result in an output register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module rwd_back
   import rwd_pkg::*;
#(
   parameter int MAX_WORKERS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               job_valid,
   input  wire job_type            job_data,
   output logic                    job_pop,
   input  wire logic               routing_mode,
   input  wire logic [COUNT_W-1:0] worker_count,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output result_type              rsp_data
);

   bk_state_type      state_ff, state_in;
   logic [SLOT_W-1:0] rr_ff, rr_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [KEY_W-1:0]  dvd_ff, dvd_in;
   logic [STEP_W-1:0] step_ff, step_in;
   result_type        res_ff, res_in;

   logic [COUNT_W-1:0] count;
   logic [COUNT_W:0]   rr_next;
   logic [COUNT_W:0]   trial;
   logic [COUNT_W:0]   trial_red;
   logic               last_step;

   assign count = (32'(worker_count) > 32'(MAX_WORKERS)) ? COUNT_W'(MAX_WORKERS)
                                                       : worker_count;

   assign rr_next   = {2'b00, rr_ff} + 6'd1;
   assign trial     = {rem_ff, dvd_ff[KEY_W-1]};
   assign trial_red = (trial >= {1'b0, count}) ? (trial - {1'b0, count}) : trial;
   assign last_step = (step_ff == STEP_W'(KEY_W - 1));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (job_valid) begin
               if (count != '0 && routing_mode == MODE_KEY && !job_data.no_space)
                  state_in = BK_DIV;
               else
                  state_in = BK_HOLD;
            end
         end
         BK_DIV: begin
            if (last_step) state_in = BK_HOLD;
         end
         BK_HOLD: begin
            if (rsp_ready) state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // Outputs and datapath.
   always_comb begin
      job_pop = 1'b0;
      rr_in   = rr_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      step_in = step_ff;
      res_in  = res_ff;
      case (state_ff)
         BK_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               res_in  = '0;
               rem_in  = '0;
               step_in = '0;
               dvd_in  = job_data.key;
               if (count == '0) begin
                  res_in.no_worker = 1'b1;
               end else if (routing_mode == MODE_ROUND_ROBIN) begin
                  if (rr_next >= {1'b0, count}) begin
                     rr_in = '0;
                  end else begin
                     rr_in = rr_next[SLOT_W-1:0];
                  end
                  res_in.worker_slot = (rr_next >= {1'b0, count}) ? '0
                                                                 : rr_next[SLOT_W-1:0];
               end else if (job_data.no_space) begin
                  res_in.no_key_found = 1'b1;
               end
            end
         end
         BK_DIV: begin
            rem_in  = trial_red[COUNT_W-1:0];
            dvd_in  = dvd_ff << 1;
            step_in = step_ff + 1'b1;
            if (last_step) res_in.worker_slot = trial_red[SLOT_W-1:0];
         end
         default: ;
      endcase
   end

   assign rsp_valid = (state_ff == BK_HOLD);
   assign rsp_data  = res_ff;

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      step_ff <= step_in;
      res_ff  <= res_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         rr_ff    <= '0;
      end else begin
         state_ff <= state_in;
         rr_ff    <= rr_in;
      end
   end

endmodule

`default_nettype wire

### sv/request_worker_dispatcher.sv
// Throughput: one request byte per cycle on req_; the parser never stalls
//   unless both job queue entries are occupied.
// Flow: the last byte writes a job into the queue; the idle executor pops it
//   and registers the result for rsp_ in round-robin mode or when a flag is
//   set, and in key mode after reducing the 32-bit key one bit per cycle.
// Reset: synchronous, active high; clears configuration registers, offset and parse state.
// ----------------------------------------------------------------------------
// request_worker_dispatcher: picks a worker slot for each request
// Bytes of a request stream in; on the last byte a worker slot is chosen
// either round robin or from the decimal key after the first space.
// ----------------------------------------------------------------------------
`default_nettype none

module request_worker_dispatcher
   import rwd_pkg::*;
#(
   parameter int MAX_WORKERS = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // Request bytes.
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] req_byte
   input  wire logic         req_tlast,   // last_byte
   // Chosen worker.
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [7:0]        rsp_tdata,   // [3:0] worker_slot, [7:4] zero
   output logic [1:0]        rsp_tuser,   // [0] no_worker, [1] no_key_found
   // Configuration writes.
   input  wire logic         csr_we,
   input  wire logic         csr_addr,
   input  wire logic [4:0]   csr_wdata
);

   // Configuration registers. The user must ensure they are only written while no request
   // is in flight, so the executor may read them directly; the block does not enforce it.
   logic               mode_ff, mode_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   always_comb begin
      mode_in  = mode_ff;
      count_in = count_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_ROUTING_MODE: mode_in  = csr_wdata[0];
            CSR_WORKER_COUNT: count_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_ROUND_ROBIN;
         count_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
      end
   end

   // Front: the parser sees every accepted byte and pushes a job on the last.
   logic       q_full;
   logic       q_not_empty;
   logic       job_push;
   logic       job_pop;
   job_type    job_in;
   job_type    job_head;
   result_type result;

   assign req_tready = !q_full;

   rwd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (req_tvalid && req_tready),
      .byte_data   (req_tdata),
      .byte_last   (req_tlast),
      .job_push    (job_push),
      .job_data    (job_in)
   );

   // Queue between the parser and the executor. Because ready drops when it
   // is full, a last byte is only accepted when there is room for its job.
   rwd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in),
      .pop       (job_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (job_head)
   );

   // Back: selects the worker and holds the result until it is taken.
   rwd_back #(
      .MAX_WORKERS (MAX_WORKERS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .job_valid    (q_not_empty),
      .job_data     (job_head),
      .job_pop      (job_pop),
      .routing_mode (mode_ff),
      .worker_count (count_ff),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_data     (result)
   );

   assign rsp_tdata = {4'b0000, result.worker_slot};
   assign rsp_tuser = {result.no_key_found, result.no_worker};

endmodule

`default_nettype wire

### sv/rwd_checker.sv
// ----------------------------------------------------------------------------
// rwd_checker: port-level checks of the request worker dispatcher
// Watches the result channel for reset, stall and flag consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module rwd_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic [1:0] rsp_tuser
);

   // No result is offered in the cycle after reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   // A stalled result stays and keeps its contents.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser))
      else $error("stalled result changed");

   // Without workers the slot is zero and no key flag is raised.
   a_no_worker: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[3:0] == 4'd0 && !rsp_tuser[1])
      else $error("inconsistent no-worker result");

   // A missing key always gives slot zero and the pad bits stay clear.
   a_no_key: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:4] == 4'd0
                     && (!rsp_tuser[1] || rsp_tdata[3:0] == 4'd0))
      else $error("bad slot encoding");

endmodule

bind request_worker_dispatcher rwd_checker u_rwd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
